// ===== hw/rtl/wmpd_pkg.sv =====
`timescale 1ns / 1ps

package wmpd_pkg;

   localparam int MAX_FRAME_BYTES = 16384;
   localparam int OFFSET_WIDTH    = $clog2(MAX_FRAME_BYTES);
   localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = OFFSET_WIDTH'(MAX_FRAME_BYTES - 1);

   localparam logic [OFFSET_WIDTH-1:0] ETH_DST_LEN     = OFFSET_WIDTH'(6);
   localparam logic [OFFSET_WIDTH-1:0] ETH_TYPE_HI_POS = OFFSET_WIDTH'(12);
   localparam logic [OFFSET_WIDTH-1:0] ETH_TYPE_LO_POS = OFFSET_WIDTH'(13);

   localparam logic [6:0] IPV4_IHL_POS    = 7'd0;
   localparam logic [6:0] IPV4_PROTO_POS  = 7'd9;
   localparam logic [6:0] IPV4_BASE_LEN   = 7'd20;
   localparam logic [6:0] IPV6_NEXT_POS   = 7'd6;
   localparam logic [6:0] IPV6_HDR_LEN    = 7'd40;
   localparam logic [6:0] UDP_PORT_HI_POS = 7'd2;
   localparam logic [6:0] UDP_PORT_LO_POS = 7'd3;
   localparam logic [6:0] UDP_HDR_LEN     = 7'd8;
   localparam logic [6:0] WOL_SYNC_LEN    = 7'd6;
   localparam logic [6:0] WOL_MAC_END     = 7'd12;
   localparam logic [6:0] WOL_PAYLOAD_LEN = 7'd102;

   localparam logic [15:0] ETHERTYPE_ZERO = 16'h0000;
   localparam logic [15:0] ETHERTYPE_WOL  = 16'h0842;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] IP6_ETHERTYPE  = 16'h86DD;
   localparam logic [15:0] PROTO_UDP      = 16'd17;
   localparam logic [15:0] WOL_UDP_PORT   = 16'd9;
   localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
   localparam logic [3:0]  IHL_MASK       = 4'hF;

   typedef enum logic [2:0] {
      PH_ETH  = 3'd0,
      PH_WOL  = 3'd1,
      PH_IPV4 = 3'd2,
      PH_IPV6 = 3'd3,
      PH_UDP  = 3'd4,
      PH_DONE = 3'd5
   } phase_type;

   typedef enum logic [3:0] {
      V_OK       = 4'd0,
      V_SHORT    = 4'd1,
      V_NOTBCAST = 4'd2,
      V_ETYPE    = 4'd3,
      V_NOTUDP   = 4'd4,
      V_PORT     = 4'd5,
      V_SYNC     = 4'd6,
      V_MAC      = 4'd7,
      V_IHL      = 4'd8
   } verdict_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic        magic_found;
      logic [47:0] target_mac;
      logic [3:0]  verdict;
   } rsp_type;

endpackage

// ===== hw/rtl/wmpd_parser.sv =====
`timescale 1ns / 1ps

module wmpd_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  wmpd_pkg::req_type req,
   output logic              result_valid,
   output wmpd_pkg::rsp_type result
);

   wmpd_pkg::phase_type                 phase_ff, phase_in;
   logic [wmpd_pkg::OFFSET_WIDTH-1:0]   byte_offset_ff, byte_offset_in;
   logic [6:0]                          section_ff, section_in;
   logic [5:0]                          header_bytes_ff, header_bytes_in;
   logic [15:0]                         type_port_ff, type_port_in;
   logic [47:0]                         mac_ff, mac_in;
   wmpd_pkg::verdict_type               verdict_ff, verdict_in;
   logic                                complete_ff, complete_in;

   logic [7:0]            b;
   logic [6:0]            sec_next;
   wmpd_pkg::verdict_type final_verdict;
   logic                  ok;

   function automatic wmpd_pkg::verdict_type note_fault(wmpd_pkg::verdict_type cur,
                                                        wmpd_pkg::verdict_type v);
      return (cur == wmpd_pkg::V_OK) ? v : cur;
   endfunction

   always_comb begin
      b               = req.data_byte;
      sec_next        = section_ff + 7'd1;
      phase_in        = phase_ff;
      section_in      = section_ff;
      header_bytes_in = header_bytes_ff;
      type_port_in    = type_port_ff;
      mac_in          = mac_ff;
      verdict_in      = verdict_ff;
      complete_in     = complete_ff;
      byte_offset_in  = (byte_offset_ff < wmpd_pkg::OFFSET_MAX) ?
                        byte_offset_ff + 1'b1 : byte_offset_ff;

      unique case (phase_ff)
         wmpd_pkg::PH_ETH: begin
            if (byte_offset_ff < wmpd_pkg::ETH_DST_LEN && b != wmpd_pkg::SYNC_BYTE) begin
               verdict_in = note_fault(verdict_in, wmpd_pkg::V_NOTBCAST);
            end
            if (byte_offset_ff == wmpd_pkg::ETH_TYPE_HI_POS) begin
               type_port_in = {b, 8'h00};
            end
            if (byte_offset_ff == wmpd_pkg::ETH_TYPE_LO_POS) begin
               type_port_in = type_port_ff | {8'h00, b};
               section_in   = '0;
               if (verdict_in != wmpd_pkg::V_OK) begin
                  phase_in = wmpd_pkg::PH_DONE;
               end else if (type_port_in == wmpd_pkg::ETHERTYPE_ZERO ||
                            type_port_in == wmpd_pkg::ETHERTYPE_WOL) begin
                  phase_in = wmpd_pkg::PH_WOL;
               end else if (type_port_in == wmpd_pkg::ETHERTYPE_IPV4) begin
                  phase_in = wmpd_pkg::PH_IPV4;
               end else if (type_port_in == wmpd_pkg::IP6_ETHERTYPE) begin
                  phase_in = wmpd_pkg::PH_IPV6;
               end else begin
                  verdict_in = note_fault(verdict_in, wmpd_pkg::V_ETYPE);
                  phase_in   = wmpd_pkg::PH_DONE;
               end
            end
         end
         wmpd_pkg::PH_IPV4: begin
            if (section_ff == wmpd_pkg::IPV4_IHL_POS) begin
               header_bytes_in = {b[3:0] & wmpd_pkg::IHL_MASK, 2'b00};
            end
            if (section_ff == wmpd_pkg::IPV4_PROTO_POS) begin
               type_port_in = {8'h00, b};
            end
            section_in = sec_next;
            if (sec_next == wmpd_pkg::IPV4_BASE_LEN &&
                {1'b0, header_bytes_in} < wmpd_pkg::IPV4_BASE_LEN) begin
               verdict_in = note_fault(verdict_in, wmpd_pkg::V_IHL);
               phase_in   = wmpd_pkg::PH_DONE;
            end else if (sec_next >= wmpd_pkg::IPV4_BASE_LEN &&
                         sec_next == {1'b0, header_bytes_in}) begin
               if (type_port_in != wmpd_pkg::PROTO_UDP) begin
                  verdict_in = note_fault(verdict_in, wmpd_pkg::V_NOTUDP);
                  phase_in   = wmpd_pkg::PH_DONE;
               end else begin
                  phase_in   = wmpd_pkg::PH_UDP;
                  section_in = '0;
               end
            end
         end
         wmpd_pkg::PH_IPV6: begin
            if (section_ff == wmpd_pkg::IPV6_NEXT_POS) begin
               type_port_in = {8'h00, b};
            end
            section_in = sec_next;
            if (sec_next == wmpd_pkg::IPV6_HDR_LEN) begin
               if (type_port_in != wmpd_pkg::PROTO_UDP) begin
                  verdict_in = note_fault(verdict_in, wmpd_pkg::V_NOTUDP);
                  phase_in   = wmpd_pkg::PH_DONE;
               end else begin
                  phase_in   = wmpd_pkg::PH_UDP;
                  section_in = '0;
               end
            end
         end
         wmpd_pkg::PH_UDP: begin
            if (section_ff == wmpd_pkg::UDP_PORT_HI_POS) begin
               type_port_in = {b, 8'h00};
            end
            if (section_ff == wmpd_pkg::UDP_PORT_LO_POS) begin
               type_port_in = type_port_ff | {8'h00, b};
            end
            section_in = sec_next;
            if (sec_next == wmpd_pkg::UDP_HDR_LEN) begin
               if (type_port_in != wmpd_pkg::WOL_UDP_PORT) begin
                  verdict_in = note_fault(verdict_in, wmpd_pkg::V_PORT);
                  phase_in   = wmpd_pkg::PH_DONE;
               end else begin
                  phase_in   = wmpd_pkg::PH_WOL;
                  section_in = '0;
               end
            end
         end
         wmpd_pkg::PH_WOL: begin
            if (section_ff < wmpd_pkg::WOL_SYNC_LEN) begin
               if (b != wmpd_pkg::SYNC_BYTE) begin
                  verdict_in = note_fault(verdict_in, wmpd_pkg::V_SYNC);
               end
            end else if (section_ff < wmpd_pkg::WOL_MAC_END) begin
               mac_in = {mac_ff[39:0], b};
            end else begin
               // compare against the top octet and rotate; 15 copies bring it back
               if (mac_ff[47:40] != b) begin
                  verdict_in = note_fault(verdict_in, wmpd_pkg::V_MAC);
               end
               mac_in = {mac_ff[39:0], mac_ff[47:40]};
            end
            section_in = sec_next;
            if (sec_next == wmpd_pkg::WOL_PAYLOAD_LEN) begin
               if (verdict_in == wmpd_pkg::V_OK) begin
                  complete_in = 1'b1;
               end
               phase_in = wmpd_pkg::PH_DONE;
            end
         end
         wmpd_pkg::PH_DONE: begin
            phase_in = wmpd_pkg::PH_DONE;
         end
         default: begin
            phase_in = wmpd_pkg::PH_DONE;
         end
      endcase

      final_verdict = (phase_in != wmpd_pkg::PH_DONE) ? wmpd_pkg::V_SHORT : verdict_in;
      ok            = (final_verdict == wmpd_pkg::V_OK) && complete_in;

      result_valid       = step && req.frame_end;
      result.magic_found = ok;
      result.target_mac  = ok ? mac_in : 48'h0;
      result.verdict     = final_verdict;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && req.frame_end)) begin
         phase_ff        <= wmpd_pkg::PH_ETH;
         byte_offset_ff  <= '0;
         section_ff      <= '0;
         header_bytes_ff <= '0;
         type_port_ff    <= '0;
         mac_ff          <= '0;
         verdict_ff      <= wmpd_pkg::V_OK;
         complete_ff     <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         byte_offset_ff  <= byte_offset_in;
         section_ff      <= section_in;
         header_bytes_ff <= header_bytes_in;
         type_port_ff    <= type_port_in;
         mac_ff          <= mac_in;
         verdict_ff      <= verdict_in;
         complete_ff     <= complete_in;
      end
   end

endmodule

// ===== hw/rtl/wol_magic_packet_detector.sv =====
`timescale 1ns / 1ps

// A verdict appears on rsp after the request carrying the last byte is accepted: that byte
// sits in the input register, passes the parse logic and is captured in the result register.
// Throughput: one byte per cycle, sustained; stalls only while a verdict waits.
// Reset: synchronous; clears all frame state and both valid flags, no clearing pass.
module wol_magic_packet_detector (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wmpd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wmpd_pkg::rsp_type rsp_payload
);

   logic              in_valid_ff, in_valid_in;
   wmpd_pkg::req_type in_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   wmpd_pkg::rsp_type rsp_ff;

   logic              out_free;
   logic              advance;
   logic              load;
   logic              result_valid;
   wmpd_pkg::rsp_type result;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_ff.frame_end || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!in_valid_ff || advance) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (result_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   wmpd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .req          (in_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_ff <= req_payload;
      end
      if (result_valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
